// ===== hdl/fskh_pkg.sv =====
`default_nettype none

package fskh_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME    = 64'h00000100000001b3;
    localparam logic [63:0] SM_GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL_A     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL_B     = 64'h94d049bb133111eb;

    // FNV prime is 2^40 + 0x1b3: the high term is a shift, the low one a small constant
    localparam int unsigned FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO    = FNV_PRIME[8:0];

    // Partial product of a 64 x 64 product modulo 2^64
    typedef enum logic [1:0] {
        PP_LL,    // a_lo * b_lo, full 64 bits, starts the sum
        PP_HL,    // a_hi * b_lo, low 32 bits into the upper half
        PP_LH     // a_lo * b_hi, low 32 bits into the upper half
    } pp_sel_t;

    typedef struct packed {
        logic    absorb;   // input word accepted this cycle
        logic    fold;     // add golden ratio, xor-shift 30, reload the basis
        logic    mul_en;   // run one partial product
        pp_sel_t pp;
        logic    mul_b;    // 0: first mix constant, 1: second
        logic    remix;    // xor-shift 27 of the first product
        logic    emit;     // xor-shift 31 into the output register
    } fskh_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/fskh_dp.sv =====
`default_nettype none

module fskh_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fskh_pkg::fskh_cmd_t cmd,
    input  wire logic [7:0]        data_byte,
    input  wire logic              byte_valid,
    output logic [63:0]            hash_key
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] x_reg;
    logic [63:0] x_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] key_reg;
    logic [63:0] key_next;

    logic [63:0] hx;
    logic [63:0] fnv_step;
    logic [63:0] seeded;
    logic [63:0] mix_const;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;

    // FNV-1a step: xor the byte, then multiply by 2^40 + 0x1b3
    always_comb
    begin
        hx       = hash_reg ^ {56'd0, data_byte};
        fnv_step = (hx << fskh_pkg::FNV_PRIME_SHIFT)
                 + hx * {55'd0, fskh_pkg::FNV_PRIME_LO};
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.fold)
        begin
            hash_next = fskh_pkg::FNV_BASIS;
        end
        else if (cmd.absorb && byte_valid)
        begin
            hash_next = fnv_step;
        end
    end

    always_comb
    begin
        seeded = hash_reg + fskh_pkg::SM_GOLDEN;
        x_next = x_reg;
        if (cmd.fold)
        begin
            x_next = seeded ^ (seeded >> 30);
        end
        else if (cmd.remix)
        begin
            x_next = acc_reg ^ (acc_reg >> 27);
        end
    end

    // One shared 32 x 32 multiplier, three partial products per 64-bit product
    always_comb
    begin
        mix_const = cmd.mul_b ? fskh_pkg::SM_MUL_B : fskh_pkg::SM_MUL_A;
        op_a      = (cmd.pp == fskh_pkg::PP_HL) ? x_reg[63:32] : x_reg[31:0];
        op_b      = (cmd.pp == fskh_pkg::PP_LH) ? mix_const[63:32] : mix_const[31:0];
        prod      = {32'd0, op_a} * {32'd0, op_b};
        acc_next  = acc_reg;
        if (cmd.mul_en)
        begin
            case (cmd.pp)
                fskh_pkg::PP_LL: acc_next = prod;
                fskh_pkg::PP_HL,
                fskh_pkg::PP_LH: acc_next = acc_reg + {prod[31:0], 32'd0};
                default:         acc_next = acc_reg;
            endcase
        end
    end

    always_comb
    begin
        key_next = key_reg;
        if (cmd.emit)
        begin
            key_next = acc_reg ^ (acc_reg >> 31);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= fskh_pkg::FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        key_reg <= key_next;
    end

    assign hash_key = key_reg;

endmodule

`default_nettype wire

// ===== hdl/fskh_ctrl.sv =====
`default_nettype none

module fskh_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                last,
    input  wire logic                out_stall,
    output logic                     in_stall,
    output logic                     out_valid,
    output fskh_pkg::fskh_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MIX2,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.pp     = fskh_pkg::PP_LL;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.absorb = in_valid;
                if (in_valid && last)
                begin
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_MA0;
            end
            ST_MA0:
            begin
                cmd.mul_en = 1'b1;
                cmd.pp     = fskh_pkg::PP_LL;
                state_next = ST_MA1;
            end
            ST_MA1:
            begin
                cmd.mul_en = 1'b1;
                cmd.pp     = fskh_pkg::PP_HL;
                state_next = ST_MA2;
            end
            ST_MA2:
            begin
                cmd.mul_en = 1'b1;
                cmd.pp     = fskh_pkg::PP_LH;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                cmd.remix  = 1'b1;
                state_next = ST_MB0;
            end
            ST_MB0:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
                cmd.pp     = fskh_pkg::PP_LL;
                state_next = ST_MB1;
            end
            ST_MB1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
                cmd.pp     = fskh_pkg::PP_HL;
                state_next = ST_MB2;
            end
            ST_MB2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
                cmd.pp     = fskh_pkg::PP_LH;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/fnv1a_splitmix_key_hasher.sv =====
`default_nettype none

// Channel | Direction | Handshake           | Word
// --------+-----------+---------------------+----------------------------------
// in      | sink      | in_valid / in_stall | data_byte, byte_valid, last
// out     | source    | out_valid/out_stall | hash_key (64-bit finalized key)
//
// Words without last are absorbed at one per cycle while in_stall is low:
// the FNV-1a step (xor, then multiply by 2^40 + 0x1b3) runs in the accept
// cycle. A word with last is absorbed too, then the splitmix64 finalizer
// runs on one shared 32 x 32 multiplier (three partial products per 64-bit
// product, two products), with in_stall high throughout.
// The key lands in an output register; a stalled key holds, and the next
// string's bytes are taken while it waits. A finished key waits in the last
// finalizer step only if the previous key is still not taken.
// Reset loads the FNV offset basis and clears out_valid.
module fnv1a_splitmix_key_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      hash_key
);

    fskh_pkg::fskh_cmd_t cmd;

    // Sequencer: accepts words, steps the finalizer, owns out_valid
    fskh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Running hash, mixing registers and the shared multiplier
    fskh_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .hash_key   (hash_key)
    );

    // A word with last must close the input for the finalizer
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last) |=> in_stall)
        else $error("input not stalled after a last word");

    // Fold only right after an accepted last word
    a_fold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> $past(in_valid && !in_stall && last))
        else $error("finalizer started without a last word");

    // An emitted key shows as valid next cycle
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted key not presented");

    // Never overwrite a key still waiting under stall
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("pending key overwritten");

    // Datapath steps are mutually exclusive
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.absorb, cmd.fold, cmd.mul_en, cmd.remix, cmd.emit}))
        else $error("overlapping datapath steps");

endmodule

`default_nettype wire

// ===== verif/key_hash_checker.sv =====
`timescale 1ns / 1ps

module key_hash_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] hash_key,
    output int          fail_count,
    output int          keys_pending
);

    logic [63:0] partial_hash;
    logic [63:0] expected_keys[$];
    int          reported;

    // One FNV-1a step, truncated to 64 bits
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b_val);
        logic [63:0] mixed;
        mixed = h ^ {56'd0, b_val};
        return mixed * fskh_pkg::FNV_PRIME;
    endfunction

    // splitmix64 finalizer over the running hash
    function automatic logic [63:0] splitmix_fold(input logic [63:0] h);
        logic [63:0] v;
        v = h + fskh_pkg::SM_GOLDEN;
        v = (v ^ (v >> 30)) * fskh_pkg::SM_MUL_A;
        v = (v ^ (v >> 27)) * fskh_pkg::SM_MUL_B;
        return v ^ (v >> 31);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        logic [63:0] next_hash;
        if (!rst_n)
        begin
            partial_hash = fskh_pkg::FNV_BASIS;
            expected_keys.delete();
            fail_count   = 0;
            keys_pending = 0;
            reported     = 0;
        end
        else
        begin
            // Retire the key first: it always belongs to an earlier string
            if (out_valid && !out_stall)
            begin
                if (expected_keys.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("[%0t] key %h with no string pending", $realtime, hash_key);
                    end
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (hash_key !== want)
                    begin
                        fail_count++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("[%0t] hash_key mismatch: expected %h, actual %h",
                                     $realtime, want, hash_key);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                next_hash = byte_valid ? fnv_absorb(partial_hash, data_byte) : partial_hash;
                if (last)
                begin
                    expected_keys = {expected_keys, splitmix_fold(next_hash)};
                    next_hash = fskh_pkg::FNV_BASIS;
                end
                partial_hash = next_hash;
            end
            keys_pending = expected_keys.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_WORDS  = 1250;  // words that absorb or close a string
    localparam int CALM_AFTER = 1100;  // no idling on either side past this count
    localparam int HOLD_LEN   = 400;   // long output hold-off to back the block up
    localparam int DRAIN_WAIT = 24;    // finalizer plus output register, with margin

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  data_byte  = 8'd0;
    logic        byte_valid = 1'b0;
    logic        last       = 1'b0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [63:0] hash_key;

    int fail_count;
    int keys_pending;
    int words_sent = 0;
    bit calm       = 1'b0;  // set for the tail of the run: both sides stop idling
    bit hold_req   = 1'b0;  // ask the receiver for its one long hold-off

    fnv1a_splitmix_key_hasher u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_key   (hash_key)
    );

    key_hash_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_key     (hash_key),
        .fail_count   (fail_count),
        .keys_pending (keys_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every word closing a string,
    // every key stalled for the longest burst, every word after the longest gap).
    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one word and hold it until the block takes it. A random gap may come
    // first; during it valid drops. Idle words (no byte, no last) are not counted.
    task automatic send_word(input logic [7:0] b_val, input logic absorb, input logic ends);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b_val;
        byte_valid <= absorb;
        last       <= ends;
        @(posedge clk);
        // in_stall read here is its value before this edge: the one that decided the accept
        while (in_stall) @(posedge clk);
        if (absorb || ends) words_sent++;
    endtask

    // Pick a byte: mostly uniform, sometimes all zeros or all ones
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one string of n_bytes bytes. Either close it on its final byte, or
    // (empty_close, or no bytes at all) with a separate last word carrying no byte.
    // Sprinkle idle words in between as noise.
    task automatic send_string(input int n_bytes, input bit empty_close);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 15) == 0) send_word(pick_byte(), 1'b0, 1'b0);
            send_word(pick_byte(), 1'b1, (i == n_bytes - 1) && !empty_close);
        end
        if (empty_close || n_bytes == 0) send_word(pick_byte(), 1'b0, 1'b1);
    endtask

    // Receiver: drop into stall bursts at random, once take a long hold-off so
    // the output register and the finalizer both fill and the block pushes back
    // on its input. Exactly one stall assignment per edge.
    initial
    begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (hold_req && !hold_done)
            begin
                stall_left = HOLD_LEN;
                hold_done  = 1'b1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 18);
            end
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        int n_bytes;
        int pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty string, with and without a junk byte on the bus
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b1);
        // Single-byte strings at the byte extremes
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        // Idle words inside a string must not disturb the hash
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b1);
        // Close a string with a last word that carries no byte
        send_word(8'hAA, 1'b1, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'h3C, 1'b0, 1'b1);
        // Back-to-back empty strings
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        // A short run of all-ones bytes
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b1);

        // Random strings: mostly short, some medium, a few long
        hold_req = 1'b1;
        while (words_sent < NUM_WORDS)
        begin
            if (words_sent >= CALM_AFTER) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5)       n_bytes = 0;
            else if (pick < 70) n_bytes = $urandom_range(1, 8);
            else if (pick < 95) n_bytes = $urandom_range(9, 24);
            else                n_bytes = $urandom_range(25, 64);
            send_string(n_bytes, $urandom_range(0, 4) == 0);
        end
        in_valid <= 1'b0;

        // Drain: wait for every key, then give the block time to emit strays
        while (keys_pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && keys_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
